### src/mlp_pkg.sv
// Package for the multichannel one-pole low-pass filter.
// Holds widths, limits, register indexes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package mlp_pkg;

  // Channel storage
  localparam int MAX_CHANNELS = 8;
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int CNT_W        = 4;

  // Sample and coefficient formats
  localparam int SAMPLE_W = 16;
  localparam int COEFF_W  = 16;
  localparam int STATE_W  = 32;          // signed Q16.16
  localparam int DIFF_W   = STATE_W + 1; // sample*2^16 - state
  localparam int PROD_W   = DIFF_W + COEFF_W + 1;

  // Scaling shifts
  localparam int COEFF_SHIFT = 15;       // Q1.15
  localparam int OUT_SHIFT   = 28;       // Q16.16 * Q4.12 -> integer
  localparam int UPD_W       = PROD_W - COEFF_SHIFT;
  localparam int ACC_W       = UPD_W + 1;
  localparam int RES_W       = PROD_W - OUT_SHIFT;

  localparam int OUT_LIMIT = (1 << 15) - 1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT   = 2'd0,
    REG_SMOOTHING_COEFF = 2'd1,
    REG_OUTPUT_GAIN     = 2'd2
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL1 = 5'b00010,
    ST_UPD  = 5'b00100,
    ST_MUL2 = 5'b01000,
    ST_OUT  = 5'b10000
  } seq_state_t;

endpackage

### src/mlp_mul.sv
// Shared signed-by-unsigned multiplier with a registered product.
// Depends on mlp_pkg for operand and product widths.
`timescale 1ns / 1ps

module mlp_mul (
  input  logic                              clk,
  input  logic signed [mlp_pkg::DIFF_W-1:0] a,
  input  logic        [mlp_pkg::COEFF_W-1:0] b,
  output logic signed [mlp_pkg::PROD_W-1:0] product
);

  logic signed [mlp_pkg::COEFF_W:0] b_signed;

  // Zero-extend the unsigned operand so the product stays signed
  assign b_signed = $signed({1'b0, b});

  // Register the product every cycle
  always_ff @(posedge clk) begin
    product <= a * b_signed;
  end

endmodule

### src/multichannel_one_pole_lowpass_top.sv
// Top level of the multichannel one-pole low-pass filter.
// Items do not overlap in the sequencer; the single shared multiplier is used
// twice per item (state update, then output gain) under a 5-state sequencer.
// A result held in the output register with m_tready low keeps the sequencer
// in its output step and stalls the input. Reset (synchronous, rst high)
// zeroes all channel states and the channel pointer, and loads channel_count 1,
// coefficient 32768, gain 4096. Depends on mlp_pkg and mlp_mul.
`timescale 1ns / 1ps

module multichannel_one_pole_lowpass_top (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [15:0]                         s_tdata,   // [15:0] sample_in
  input  logic                                s_tuser,   // [0] packet_start
  // Output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [15:0]                         m_tdata,   // [15:0] sample_out
  output logic [2:0]                          m_tuser,   // [2:0] channel_of_sample
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mlp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [15:0]                         cfg_data
);

  mlp_pkg::seq_state_t state, state_next;

  logic [mlp_pkg::CNT_W-1:0]   channel_count;
  logic [mlp_pkg::COEFF_W-1:0] smoothing_coeff;
  logic [mlp_pkg::COEFF_W-1:0] output_gain;

  logic signed [mlp_pkg::STATE_W-1:0] channel_states [mlp_pkg::MAX_CHANNELS];
  logic [mlp_pkg::CH_W-1:0]           channel_pointer;

  logic [mlp_pkg::CH_W-1:0]           ch;
  logic signed [mlp_pkg::STATE_W-1:0] st;
  logic signed [mlp_pkg::DIFF_W-1:0]  diff;
  logic signed [mlp_pkg::STATE_W-1:0] ns;

  logic                               in_accept;
  logic [mlp_pkg::CH_W-1:0]           ch_sel;
  logic signed [mlp_pkg::DIFF_W-1:0]  diff_next;
  logic [mlp_pkg::CNT_W-1:0]          eff_count;
  logic [mlp_pkg::CNT_W-1:0]          ch_inc;
  logic [mlp_pkg::CH_W-1:0]           pointer_next;

  logic signed [mlp_pkg::DIFF_W-1:0]  mul_a;
  logic        [mlp_pkg::COEFF_W-1:0] mul_b;
  logic signed [mlp_pkg::PROD_W-1:0]  product;

  logic signed [mlp_pkg::PROD_W-1:0]  upd_biased;
  logic signed [mlp_pkg::UPD_W-1:0]   upd_delta;
  logic signed [mlp_pkg::ACC_W-1:0]   ns_wide;
  logic signed [mlp_pkg::STATE_W-1:0] ns_next;

  logic signed [mlp_pkg::PROD_W-1:0]  out_biased;
  logic signed [mlp_pkg::RES_W-1:0]   res_wide;
  logic signed [mlp_pkg::SAMPLE_W-1:0] res_clamped;
  logic                               out_load;

  assign cfg_ready = !rst;
  assign s_tready  = (state == mlp_pkg::ST_IDLE) && !rst;
  assign in_accept = s_tvalid && s_tready;
  assign out_load  = (state == mlp_pkg::ST_OUT) && (!m_tvalid || m_tready);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count   <= mlp_pkg::CNT_W'(1);
      smoothing_coeff <= mlp_pkg::COEFF_W'(32768);
      output_gain     <= mlp_pkg::COEFF_W'(4096);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mlp_pkg::REG_CHANNEL_COUNT:   channel_count   <= cfg_data[mlp_pkg::CNT_W-1:0];
        mlp_pkg::REG_SMOOTHING_COEFF: smoothing_coeff <= cfg_data;
        mlp_pkg::REG_OUTPUT_GAIN:     output_gain     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Channel selection and next pointer; zero count means one channel, above eight means eight
  always_comb begin
    ch_sel = s_tuser ? '0 : channel_pointer;
    if (channel_count == '0) begin
      eff_count = mlp_pkg::CNT_W'(1);
    end else if (channel_count > mlp_pkg::CNT_W'(mlp_pkg::MAX_CHANNELS)) begin
      eff_count = mlp_pkg::CNT_W'(mlp_pkg::MAX_CHANNELS);
    end else begin
      eff_count = channel_count;
    end
    ch_inc       = mlp_pkg::CNT_W'(ch_sel) + mlp_pkg::CNT_W'(1);
    pointer_next = (ch_inc >= eff_count) ? '0 : ch_inc[mlp_pkg::CH_W-1:0];
    diff_next    = mlp_pkg::DIFF_W'($signed({s_tdata, 16'h0000}))
                 - mlp_pkg::DIFF_W'(channel_states[ch_sel]);
  end

  // Shared multiplier operand select
  always_comb begin
    if (state == mlp_pkg::ST_MUL1) begin
      mul_a = diff;
      mul_b = smoothing_coeff;
    end else begin
      mul_a = mlp_pkg::DIFF_W'(ns);
      mul_b = output_gain;
    end
  end

  mlp_mul u_mul (
    .clk     (clk),
    .a       (mul_a),
    .b       (mul_b),
    .product (product)
  );

  // State update: truncate toward zero, add, saturate to 32 bits
  always_comb begin
    upd_biased = product + (product[mlp_pkg::PROD_W-1]
               ? mlp_pkg::PROD_W'((1 << mlp_pkg::COEFF_SHIFT) - 1) : '0);
    upd_delta  = upd_biased[mlp_pkg::PROD_W-1:mlp_pkg::COEFF_SHIFT];
    ns_wide    = mlp_pkg::ACC_W'(st) + mlp_pkg::ACC_W'(upd_delta);
    if (ns_wide[mlp_pkg::ACC_W-1:mlp_pkg::STATE_W-1] == '0 ||
        ns_wide[mlp_pkg::ACC_W-1:mlp_pkg::STATE_W-1] == '1) begin
      ns_next = ns_wide[mlp_pkg::STATE_W-1:0];
    end else if (ns_wide[mlp_pkg::ACC_W-1]) begin
      ns_next = {1'b1, {(mlp_pkg::STATE_W-1){1'b0}}};
    end else begin
      ns_next = {1'b0, {(mlp_pkg::STATE_W-1){1'b1}}};
    end
  end

  // Output scaling: truncate toward zero, clamp to the symmetric limit
  always_comb begin
    out_biased = product + (product[mlp_pkg::PROD_W-1]
               ? mlp_pkg::PROD_W'((1 << mlp_pkg::OUT_SHIFT) - 1) : '0);
    res_wide   = out_biased[mlp_pkg::PROD_W-1:mlp_pkg::OUT_SHIFT];
    if (res_wide > mlp_pkg::RES_W'(mlp_pkg::OUT_LIMIT)) begin
      res_clamped = mlp_pkg::SAMPLE_W'(mlp_pkg::OUT_LIMIT);
    end else if (res_wide < -mlp_pkg::RES_W'(mlp_pkg::OUT_LIMIT)) begin
      res_clamped = -mlp_pkg::SAMPLE_W'(mlp_pkg::OUT_LIMIT);
    end else begin
      res_clamped = res_wide[mlp_pkg::SAMPLE_W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      mlp_pkg::ST_IDLE: if (in_accept) state_next = mlp_pkg::ST_MUL1;
      mlp_pkg::ST_MUL1: state_next = mlp_pkg::ST_UPD;
      mlp_pkg::ST_UPD:  state_next = mlp_pkg::ST_MUL2;
      mlp_pkg::ST_MUL2: state_next = mlp_pkg::ST_OUT;
      mlp_pkg::ST_OUT:  if (out_load) state_next = mlp_pkg::ST_IDLE;
      default:          state_next = mlp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the item's channel, old state and difference on acceptance, and the new state in the update step
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ch   <= ch_sel;
      st   <= channel_states[ch_sel];
      diff <= diff_next;
    end
    if (state == mlp_pkg::ST_UPD) begin
      ns <= ns_next;
    end
  end

  // Channel pointer and per-channel filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_pointer <= '0;
      for (int i = 0; i < mlp_pkg::MAX_CHANNELS; i++) begin
        channel_states[i] <= '0;
      end
    end else begin
      if (in_accept) begin
        channel_pointer <= pointer_next;
      end
      if (state == mlp_pkg::ST_UPD) begin
        channel_states[ch] <= ns_next;
      end
    end
  end

  // Output register; hold until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= res_clamped;
      m_tuser <= ch;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !s_tready)
    else $error("input accepted again while an item is in flight");

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> ##3 (state == mlp_pkg::ST_OUT))
    else $error("sequencer did not reach the output step on time");

  a_packet_start_ch0: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_tuser) |=> (ch == '0))
    else $error("packet start did not select channel zero");

  a_out_clamped: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata != 16'h8000))
    else $error("output sample outside the symmetric clamp range");
`endif

endmodule
